/* rtl/core/lgv_pkg.sv */
// Shared types, constants and helpers for the local gravity vector pipeline.
package lgv_pkg;

  // Fixed-point constants (Q30 angles and ratios, Q24 accelerations)
  localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [34:0] R0_MM       = 35'sd6371008000;
  localparam logic [33:0]        R0_HALF_MM  = 34'd3185504000;
  localparam logic signed [28:0] G_EQ_Q24    = 29'sd164086508;
  localparam logic signed [28:0] G_STD_Q24   = 29'sd164528285;
  localparam logic signed [23:0] K1_Q30      = 24'sd5693409;
  localparam logic signed [13:0] K2_Q30      = 14'sd6335;
  localparam logic signed [27:0] W2_PER_MM   = 28'sd98090453;

  // Output range
  localparam logic signed [63:0] OUT_MAX = 64'sd268435455;
  localparam logic signed [63:0] OUT_MIN = -64'sd268435456;

  // Quotient bits of the radius ratio divider
  localparam int DIV_STEPS = 31;

  // Register indexes
  localparam logic REG_FRAME = 1'b0;
  localparam logic REG_STD   = 1'b1;

  // One CORDIC lane entry
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
    logic [33:0]        r;
  } cordic_t;

  // One divider lane entry
  typedef struct packed {
    logic signed [31:0] cl;
    logic signed [31:0] sl;
    logic [33:0]        r;
    logic [34:0]        rem;
    logic [30:0]        q;
  } div_t;

  // arctan(2^-i) in Q30
  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] v;
    unique case (i)
      0:  v = 31'd843314856;
      1:  v = 31'd497837829;
      2:  v = 31'd263043836;
      3:  v = 31'd133525158;
      4:  v = 31'd67021686;
      5:  v = 31'd33543515;
      6:  v = 31'd16775850;
      7:  v = 31'd8388437;
      8:  v = 31'd4194282;
      9:  v = 31'd2097149;
      10: v = 31'd1048575;
      11: v = 31'd524287;
      12: v = 31'd262143;
      13: v = 31'd131071;
      14: v = 31'd65535;
      15: v = 31'd32767;
      16: v = 31'd16383;
      17: v = 31'd8191;
      18: v = 31'd4095;
      19: v = 31'd2047;
      20: v = 31'd1023;
      21: v = 31'd511;
      22: v = 31'd255;
      23: v = 31'd127;
      24: v = 31'd63;
      25: v = 31'd31;
      26: v = 31'd15;
      27: v = 31'd8;
      28: v = 31'd4;
      29: v = 31'd2;
      30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // Clamp to the 29-bit signed output range
  function automatic logic signed [28:0] sat29(input logic signed [63:0] v);
    logic signed [28:0] o;
    if (v > OUT_MAX) o = OUT_MAX[28:0];
    else if (v < OUT_MIN) o = OUT_MIN[28:0];
    else o = v[28:0];
    return o;
  endfunction

endpackage

/* rtl/core/local_gravity_vector.sv */
// Local gravity vector: CORDIC, radius divider and gravity arithmetic pipeline.
//
//  channel   signals                                   direction
//  request   in_valid/in_ready, latitude, height_mm    in
//  result    out_valid/out_ready, accel_x/y/z          out
//  config    cfg_we, cfg_index, cfg_data               in (write only)
//
// One request per cycle while the result is not stalled; stages in order: fold stage,
// CORDIC stages, one setup stage, 31 divider stages, five multiply stages,
// one output stage.
// The divider, one quotient bit per stage, sets the depth.
// Synchronous reset clears valid bits and registers; payload is not reset.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module local_gravity_vector #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [30:0] latitude,
  input  logic signed [27:0] height_mm,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [28:0] accel_x,
  output logic signed [28:0] accel_y,
  output logic signed [28:0] accel_z,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_data
);

  localparam int DS = lgv_pkg::DIV_STEPS;

  logic frame_select;
  logic use_standard_gravity;
  logic adv;

  // Global advance: the pipeline moves when the output slot is free or taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_select         <= 1'b0;
      use_standard_gravity <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lgv_pkg::REG_FRAME: frame_select         <= cfg_data;
        lgv_pkg::REG_STD:   use_standard_gravity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fold stage: angle doubled to Q30, folded into +-pi/2, radius formed
  lgv_pkg::cordic_t   cs [0:CORDIC_STAGES];
  logic               cv [0:CORDIC_STAGES];
  logic signed [33:0] theta;
  logic signed [33:0] zfold;
  logic               flip;
  logic signed [34:0] rsum;

  always_comb begin
    theta = {{2{latitude[30]}}, latitude, 1'b0};
    rsum  = lgv_pkg::R0_MM + 35'(height_mm);
    if (theta > 34'(lgv_pkg::HALF_PI_Q30)) begin
      zfold = theta - lgv_pkg::PI_Q30;
      flip  = 1'b1;
    end else if (theta < -34'(lgv_pkg::HALF_PI_Q30)) begin
      zfold = theta + lgv_pkg::PI_Q30;
      flip  = 1'b1;
    end else begin
      zfold = theta;
      flip  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs[0].x    <= lgv_pkg::CORDIC_GAIN;
      cs[0].y    <= '0;
      cs[0].z    <= zfold;
      cs[0].flip <= flip;
      cs[0].r    <= rsum[33:0];
    end
  end

  // CORDIC rotation stages
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    assign dx = cs[i].y >>> i;
    assign dy = cs[i].x >>> i;
    assign at = $signed({3'b000, lgv_pkg::atan_q30(i)});

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (adv) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cs[i+1].flip <= cs[i].flip;
        cs[i+1].r    <= cs[i].r;
        if (!cs[i].z[33]) begin
          cs[i+1].x <= cs[i].x - dx;
          cs[i+1].y <= cs[i].y + dy;
          cs[i+1].z <= cs[i].z - at;
        end else begin
          cs[i+1].x <= cs[i].x + dx;
          cs[i+1].y <= cs[i].y - dy;
          cs[i+1].z <= cs[i].z + at;
        end
      end
    end
  end

  // Divider setup: apply fold sign, start remainder at R0/2
  lgv_pkg::div_t      ds [0:DS];
  logic               dv [0:DS];
  logic signed [33:0] xf;
  logic signed [33:0] yf;

  assign xf = cs[CORDIC_STAGES].flip ? -cs[CORDIC_STAGES].x : cs[CORDIC_STAGES].x;
  assign yf = cs[CORDIC_STAGES].flip ? -cs[CORDIC_STAGES].y : cs[CORDIC_STAGES].y;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0].cl  <= xf[31:0];
      ds[0].sl  <= yf[31:0];
      ds[0].r   <= cs[CORDIC_STAGES].r;
      ds[0].rem <= {1'b0, lgv_pkg::R0_HALF_MM};
      ds[0].q   <= '0;
    end
  end

  // Restoring divider (R0 << 30) / r, one quotient bit per stage
  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [34:0] rem2;
    assign rem2 = {ds[k].rem[33:0], 1'b0};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ds[k+1].cl <= ds[k].cl;
        ds[k+1].sl <= ds[k].sl;
        ds[k+1].r  <= ds[k].r;
        if (rem2 >= {1'b0, ds[k].r}) begin
          ds[k+1].rem <= rem2 - {1'b0, ds[k].r};
          ds[k+1].q   <= {ds[k].q[29:0], 1'b1};
        end else begin
          ds[k+1].rem <= rem2;
          ds[k+1].q   <= {ds[k].q[29:0], 1'b0};
        end
      end
    end
  end

  // Arithmetic stage valid bits
  logic [5:1] mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      mv        <= {mv[4:1], dv[DS]};
      out_valid <= mv[5];
    end
  end

  // M1: squares, cross product, ratio square, centripetal product
  logic signed [63:0] s2p, scp, c2p, q2p, cenp;
  logic signed [31:0] qs;
  logic signed [34:0] rs;
  assign qs = {1'b0, ds[DS].q};
  assign rs = {1'b0, ds[DS].r};

  always_ff @(posedge clk) begin
    if (adv) begin
      s2p  <= ds[DS].sl * ds[DS].sl;
      scp  <= ds[DS].sl * ds[DS].cl;
      c2p  <= ds[DS].cl * ds[DS].cl;
      q2p  <= qs * qs;
      cenp <= rs * lgv_pkg::W2_PER_MM;
    end
  end

  // M2: sin^2 2L and K1 term
  logic signed [31:0] s2, sc, c2, q2m1, sc2;
  logic signed [23:0] cenm1;
  logic signed [63:0] s22p, k1p;
  logic signed [31:0] sc_2, c2_2, q2_2;
  logic signed [23:0] cen_2;
  assign s2    = s2p[61:30];
  assign sc    = scp[61:30];
  assign c2    = c2p[61:30];
  assign q2m1  = q2p[61:30];
  assign cenm1 = cenp[63:40];
  assign sc2   = {sc[30:0], 1'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      s22p  <= sc2 * sc2;
      k1p   <= lgv_pkg::K1_Q30 * s2;
      sc_2  <= sc;
      c2_2  <= c2;
      q2_2  <= q2m1;
      cen_2 <= cenm1;
    end
  end

  // M3: K2 term and centripetal components
  logic signed [31:0] s22;
  logic signed [63:0] k2p, nprod, dprod, k1p_3;
  logic signed [31:0] q2_3;
  assign s22 = s22p[61:30];

  always_ff @(posedge clk) begin
    if (adv) begin
      k2p   <= lgv_pkg::K2_Q30 * s22;
      nprod <= cen_2 * sc_2;
      dprod <= cen_2 * c2_2;
      k1p_3 <= k1p;
      q2_3  <= q2_2;
    end
  end

  // M4: latitude factor times equatorial gravity
  logic signed [63:0] fac_w;
  logic signed [31:0] fac;
  logic signed [63:0] gnp, nprod_4, dprod_4;
  logic signed [31:0] q2_4;
  assign fac_w = 64'(lgv_pkg::ONE_Q30) + (k1p_3 >>> 30) - (k2p >>> 30);
  assign fac   = fac_w[31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      gnp     <= lgv_pkg::G_EQ_Q24 * fac;
      nprod_4 <= nprod;
      dprod_4 <= dprod;
      q2_4    <= q2_3;
    end
  end

  // M5: height scaling
  logic signed [31:0] gn;
  logic signed [63:0] ghp, nprod_5, dprod_5;
  assign gn = gnp[61:30];

  always_ff @(posedge clk) begin
    if (adv) begin
      ghp     <= gn * q2_4;
      nprod_5 <= nprod_4;
      dprod_5 <= dprod_4;
    end
  end

  // Output: plumb-bob removal, mode and frame select, saturation
  logic signed [63:0] north, down, nsel, dsel;
  always_comb begin
    north = -(nprod_5 >>> 30);
    down  = (ghp >>> 30) - (dprod_5 >>> 30);
    if (use_standard_gravity) begin
      nsel = '0;
      dsel = 64'(lgv_pkg::G_STD_Q24);
    end else begin
      nsel = north;
      dsel = down;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (frame_select) begin
        accel_x <= '0;
        accel_y <= lgv_pkg::sat29(nsel);
        accel_z <= lgv_pkg::sat29(-dsel);
      end else begin
        accel_x <= lgv_pkg::sat29(nsel);
        accel_y <= '0;
        accel_z <= lgv_pkg::sat29(dsel);
      end
    end
  end

  // Checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");
  a_ned_east_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_select) |-> accel_y == '0)
    else $error("east component nonzero in NED frame");
  a_std_north_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && use_standard_gravity) |-> (accel_x == '0 && accel_y == '0))
    else $error("horizontal component nonzero in standard gravity mode");

endmodule
